### rtl/core/isort_pkg.sv
// Shared types, state codes and compare function for the insertion sorter.
// No dependencies; used by isort_cell and insertion_sorter.
`timescale 1ns / 1ps

package isort_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      batch_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_res;
        logic                      overflow;
    } t_out_beat;

    typedef struct packed {
        logic insert;
        logic shift;
        logic ascending;
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // True when the new key must sit ahead of the stored value.
    function automatic logic key_before(
        input logic signed [VALUE_W-1:0] stored,
        input logic signed [VALUE_W-1:0] key,
        input logic                      ascending
    );
        key_before = ascending ? (stored > key) : (key > stored);
    endfunction

endpackage

### rtl/core/isort_cell.sv
// One slot of the insertion chain: holds a value, makes room on insert,
// passes its value toward the head while the batch drains. Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_cell (
    input  logic                               i_clk,
    input  isort_pkg::t_cell_ctl               i_ctl,
    input  logic signed [isort_pkg::VALUE_W-1:0] i_key,
    input  logic                               i_occupied,
    input  logic                               i_prev_move,
    input  logic                               i_right_move,
    input  logic signed [isort_pkg::VALUE_W-1:0] i_left_data,
    input  logic signed [isort_pkg::VALUE_W-1:0] i_right_data,
    output logic signed [isort_pkg::VALUE_W-1:0] o_data,
    output logic                               o_move
);

    logic signed [isort_pkg::VALUE_W-1:0] r_data;
    logic signed [isort_pkg::VALUE_W-1:0] n_data;
    logic                                 move_here;

    assign move_here = !i_occupied || isort_pkg::key_before(r_data, i_key, i_ctl.ascending);
    assign o_move    = move_here && i_right_move;
    assign o_data    = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.insert && o_move) begin
            n_data = i_prev_move ? i_left_data : i_key;
        end else if (i_ctl.shift) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

### rtl/core/insertion_sorter.sv
// Insertion sorter top level: chain of isort_cell slots, fill count, drain FSM.
// One item is accepted per cycle while loading; an accepted item sits in its sorted slot the cycle after.
// A batch_end beat starts draining the next cycle: one result per cycle, one result per stored value.
// busy is high while draining; results come one per cycle and cannot be stalled.
// Synchronous active-low reset empties the chain, clears overflow, sets ascending order.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module insertion_sorter #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  isort_pkg::t_in_beat  i_in,
    output logic                 strobe,
    output isort_pkg::t_out_beat o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    isort_pkg::t_state    r_state;
    isort_pkg::t_state    n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_ovf;
    logic                 n_ovf;
    logic                 r_asc;
    logic                 accept;
    logic                 full;
    isort_pkg::t_cell_ctl ctl;

    logic signed [isort_pkg::VALUE_W-1:0] cell_data [DEPTH];
    logic                                 cell_move [DEPTH];

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign full        = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_state = r_state;
        case (r_state)
            isort_pkg::ST_LOAD: begin
                if (accept && i_in.batch_end) begin
                    n_state = isort_pkg::ST_EMIT;
                end
            end
            isort_pkg::ST_EMIT: begin
                if (r_count == CNT_W'(1)) begin
                    n_state = isort_pkg::ST_LOAD;
                end
            end
            default: n_state = isort_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        busy   = 1'b0;
        strobe = 1'b0;
        ctl    = '{insert: 1'b0, shift: 1'b0, ascending: r_asc};
        case (r_state)
            isort_pkg::ST_LOAD: begin
                ctl.insert = accept && !full;
            end
            isort_pkg::ST_EMIT: begin
                busy      = 1'b1;
                strobe    = 1'b1;
                ctl.shift = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end
        if (accept && full) begin
            n_ovf = 1'b1;
        end
        if (ctl.shift) begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isort_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_asc   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (i_cfg_valid && o_cfg_ready) begin
                r_asc <= i_cfg_data;
            end
        end
    end

    assign o_out.sorted_value = cell_data[0];
    assign o_out.final_res    = (r_count == CNT_W'(1));
    assign o_out.overflow     = r_ovf;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [isort_pkg::VALUE_W-1:0] left_data;
        logic signed [isort_pkg::VALUE_W-1:0] right_data;
        logic                                 prev_move;
        logic                                 right_move;

        if (i == 0) begin : g_head
            assign left_data = i_in.value;
            assign prev_move = 1'b0;
        end else begin : g_body
            assign left_data = cell_data[i-1];
            assign prev_move = cell_move[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data = cell_data[i];
            assign right_move = 1'b1;
        end else begin : g_mid
            assign right_data = cell_data[i+1];
            assign right_move = cell_move[i+1];
        end

        isort_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_key        (i_in.value),
            .i_occupied   (CNT_W'(i) < r_count),
            .i_prev_move  (prev_move),
            .i_right_move (right_move),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .o_data       (cell_data[i]),
            .o_move       (cell_move[i])
        );
    end

endmodule
